/* design/fvn_pkg.sv */
// Shared types and constants for the fractal value noise block.
// No dependencies; imported by every other design file.
package fvn_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int REG_W     = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQUENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED     = 2'd2;

  localparam logic [REG_W-1:0] AMPLITUDE_RESET      = 24'd196608;
  localparam logic [REG_W-1:0] BASE_FREQUENCY_RESET = 24'd6554;
  localparam logic [31:0]      NOISE_SEED_RESET     = 32'd0;

  localparam logic [31:0] LAT_Z_MUL   = 32'd57;
  localparam logic [31:0] SEED_MUL    = 32'd131;
  localparam logic [31:0] SEED_STEP   = 32'd1000;
  localparam int          HASH_SHIFT  = 13;
  localparam logic [31:0] HASH_MUL_A  = 32'd15731;
  localparam logic [31:0] HASH_ADD_A  = 32'd789221;
  localparam logic [31:0] HASH_ADD_B  = 32'd1376312589;

  typedef struct packed {
    logic [REG_W-1:0] amplitude;
    logic [REG_W-1:0] base_frequency;
    logic [31:0]      noise_seed;
  } cfg_t;

endpackage

/* design/fvn_hash.sv */
// Three-stage lattice corner hash, mapping a corner key to a value in (-1, 1].
// Depends on fvn_pkg.
module fvn_hash #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            key,
  output logic signed [FRAC_BITS+1:0] value
);
  import fvn_pkg::*;

  localparam int VW = FRAC_BITS + 2;

  logic [31:0] nh;
  logic [31:0] n_a, nn_a, n_b, q_b, m_c;

  assign nh  = key ^ (key << HASH_SHIFT);
  assign m_c = n_b * q_b + HASH_ADD_B;

  always_ff @(posedge clk) begin
    if (en) begin
      n_a   <= nh;
      nn_a  <= nh * nh;
      n_b   <= n_a;
      q_b   <= nn_a * HASH_MUL_A + HASH_ADD_A;
      // drop the sign bit, keep the top F+1 bits of the 31-bit hash
      value <= $signed(VW'(1) << FRAC_BITS)
             - $signed({1'b0, m_c[30:30-FRAC_BITS]});
    end
  end
endmodule

/* design/fvn_octave.sv */
// One octave lane: lattice split, corner hashes, smoothstep, blends, scaling.
// Depends on fvn_pkg and fvn_hash; seven register stages.
module fvn_octave #(
  parameter int FRAC_BITS = 16,
  parameter int LANE      = 0,
  parameter int P0W       = 57,
  parameter int TW        = 44
) (
  input  logic                   clk,
  input  logic                   en,
  input  fvn_pkg::cfg_t          cfg,
  input  logic signed [P0W-1:0]  p0x,
  input  logic signed [P0W-1:0]  p0z,
  output logic signed [TW-1:0]   term
);
  import fvn_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int PXW = 2 * F + 32;
  localparam int VW  = F + 2;
  localparam int RW  = F + 3;

  logic signed [PXW-1:0] px, pz;
  logic [31:0] ix, iz, sk, n00_c;
  logic [F-1:0] tx_c, tz_c;

  assign px    = PXW'(p0x) <<< LANE;
  assign pz    = PXW'(p0z) <<< LANE;
  assign ix    = px[2*F +: 32];
  assign iz    = pz[2*F +: 32];
  assign tx_c  = px[F +: F];
  assign tz_c  = pz[F +: F];
  assign sk    = cfg.noise_seed + SEED_STEP * 32'(LANE);
  assign n00_c = ix + LAT_Z_MUL * iz + SEED_MUL * sk;

  // stage A
  logic [31:0]  n00;
  logic [F-1:0] tx_a, tz_a, ux_a, uz_a;
  logic [2*F-1:0] ttx, ttz;
  assign ttx = tx_c * tx_c;
  assign ttz = tz_c * tz_c;

  always_ff @(posedge clk) begin
    if (en) begin
      n00  <= n00_c;
      tx_a <= tx_c;
      tz_a <= tz_c;
      ux_a <= ttx[2*F-1:F];
      uz_a <= ttz[2*F-1:F];
    end
  end

  // stages B to D: corner hashes alongside the smoothstep weights
  logic signed [VW-1:0] v00, v10, v01, v11;
  fvn_hash #(.FRAC_BITS(F)) u_h00 (.clk, .en, .key(n00),          .value(v00));
  fvn_hash #(.FRAC_BITS(F)) u_h10 (.clk, .en, .key(n00 + 32'd1),  .value(v10));
  fvn_hash #(.FRAC_BITS(F)) u_h01 (.clk, .en, .key(n00 + 32'd57), .value(v01));
  fvn_hash #(.FRAC_BITS(F)) u_h11 (.clk, .en, .key(n00 + 32'd58), .value(v11));

  logic [F+1:0]   wx, wz;
  logic [2*F+1:0] swx, swz;
  logic [F:0] sx_b, sz_b, sx_c, sz_c, sx_d, sz_d, sz_e;
  assign wx  = ((F+2)'(3) << F) - {1'b0, tx_a, 1'b0};
  assign wz  = ((F+2)'(3) << F) - {1'b0, tz_a, 1'b0};
  assign swx = ux_a * wx;
  assign swz = uz_a * wz;

  always_ff @(posedge clk) begin
    if (en) begin
      sx_b <= swx[2*F:F];
      sz_b <= swz[2*F:F];
      sx_c <= sx_b;
      sz_c <= sz_b;
      sx_d <= sx_c;
      sz_d <= sz_c;
    end
  end

  // stage E: blend along x
  logic signed [VW:0]        d0, d1;
  logic signed [VW+F+2:0]    pr0, pr1;
  logic signed [RW-1:0]      row0, row1;
  assign d0  = (VW+1)'(v10) - (VW+1)'(v00);
  assign d1  = (VW+1)'(v11) - (VW+1)'(v01);
  assign pr0 = $signed({1'b0, sx_d}) * d0;
  assign pr1 = $signed({1'b0, sx_d}) * d1;

  always_ff @(posedge clk) begin
    if (en) begin
      row0 <= RW'(v00) + RW'(pr0 >>> F);
      row1 <= RW'(v01) + RW'(pr1 >>> F);
      sz_e <= sz_d;
    end
  end

  // stage F: blend along z
  logic signed [RW:0]     d2;
  logic signed [RW+F+1:0] pr2;
  logic signed [RW-1:0]   noise;
  assign d2  = (RW+1)'(row1) - (RW+1)'(row0);
  assign pr2 = $signed({1'b0, sz_e}) * d2;

  always_ff @(posedge clk) begin
    if (en) noise <= row0 + RW'(pr2 >>> F);
  end

  // stage G: amplitude scaled down by 2^(F+LANE), floor
  logic signed [RW+REG_W:0] ta;
  assign ta = noise * $signed({1'b0, cfg.amplitude});

  always_ff @(posedge clk) begin
    if (en) term <= TW'(ta >>> (F + LANE));
  end
endmodule

/* design/fractal_value_noise_2d_top.sv */
// Fractal 2D value noise: one height beat per input beat, in order.
// Throughput one point per cycle; all octaves run as parallel lanes, and
// the whole pipeline holds when the output beat is not taken.
// Reset (rst, synchronous) clears the valid bits and loads the register
// defaults: amplitude 3.0, base_frequency about 0.1, noise_seed 0.
// Depends on fvn_pkg, fvn_octave and fvn_hash.
module fractal_value_noise_2d_top #(
  parameter int OCTAVES   = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // input beats: tdata = x_coord[31:0], z_coord[63:32]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [63:0]                    s_tdata,
  // result beats: tdata = height[31:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import fvn_pkg::*;

  localparam int P0W   = 32 + REG_W + 1;
  localparam int RW    = FRAC_BITS + 3;
  localparam int TW    = RW + REG_W + 1;
  localparam int SW    = TW + 4;
  localparam int DEPTH = 9;

  // Registers: writes are always taken; an unknown index does nothing.
  cfg_t cfg;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amplitude      <= AMPLITUDE_RESET;
      cfg.base_frequency <= BASE_FREQUENCY_RESET;
      cfg.noise_seed     <= NOISE_SEED_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AMPLITUDE:      cfg.amplitude      <= cfg_data[REG_W-1:0];
        CFG_BASE_FREQUENCY: cfg.base_frequency <= cfg_data[REG_W-1:0];
        CFG_NOISE_SEED:     cfg.noise_seed     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output slot is free or taken.
  logic en;
  logic [DEPTH-1:0] vld;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], s_tvalid};
  end

  // Stage 1: scale both coordinates by the base frequency; lanes shift by k.
  logic signed [P0W-1:0] p0x, p0z;
  always_ff @(posedge clk) begin
    if (en) begin
      p0x <= $signed(s_tdata[31:0])  * $signed({1'b0, cfg.base_frequency});
      p0z <= $signed(s_tdata[63:32]) * $signed({1'b0, cfg.base_frequency});
    end
  end

  // Stages 2 to 8: one lane per octave.
  logic signed [TW-1:0] terms [OCTAVES];
  for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
    fvn_octave #(
      .FRAC_BITS(FRAC_BITS), .LANE(k), .P0W(P0W), .TW(TW)
    ) u_oct (
      .clk, .en, .cfg, .p0x, .p0z, .term(terms[k])
    );
  end

  // Stage 9: sum the octave terms and saturate to the signed 32-bit range.
  logic signed [SW-1:0] sum;
  always_comb begin
    sum = '0;
    for (int k = 0; k < OCTAVES; k++) sum = sum + SW'(terms[k]);
  end

  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sd2147483648);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum > SAT_HI)      m_tdata <= 32'h7FFF_FFFF;
      else if (sum < SAT_LO) m_tdata <= 32'h8000_0000;
      else                   m_tdata <= sum[31:0];
    end
  end
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for fractal_value_noise_2d_top: a fixed-point fBm predictor
// and a height scoreboard. Depends on fvn_pkg and the block's RTL only.
module tb;
  import fvn_pkg::*;

  localparam int F      = 16;
  localparam int OCT    = 4;
  localparam int LAT    = 9;
  localparam int WDOG   = 20000;
  localparam int N_RAND = 800;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [31:0] m_tdata;
  logic        cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // current register image, mirrored as writes are accepted
  logic [23:0] amp_q, freq_q;
  logic [31:0] seed_q;
  int          idle_cycles;
  int          n_points;

  fractal_value_noise_2d_top DUT (.*);

  // Height predictor and queue of pending heights.
  class height_board;
    logic signed [31:0] pending[$];
    int errors, checked;

    static function automatic longint fshr(longint v, int sh);
      return v >>> sh;   // arithmetic shift floors toward minus infinity
    endfunction

    static function automatic longint corner(logic [31:0] ix, logic [31:0] iz,
                                             logic [31:0] sd);
      logic [31:0] n, m;
      n = ix + iz * 32'd57 + sd * 32'd131;
      n = (n << 13) ^ n;
      m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7FFF_FFFF;
      return (longint'(1) << F) - longint'(m >> (30 - F));
    endfunction

    static function automatic longint smooth(longint t);
      longint u;
      u = (t * t) >>> F;
      return (u * (3 * (longint'(1) << F) - 2 * t)) >>> F;
    endfunction

    static function automatic longint mix(longint a, longint b, longint s);
      return a + fshr(s * (b - a), F);
    endfunction

    static function automatic logic signed [31:0] fbm_height(
        logic signed [31:0] x, logic signed [31:0] z,
        logic [23:0] amp, logic [23:0] freq, logic [31:0] seed);
      longint sum, px, pz, tx, tz, sx, sz, r0, r1, nz, fq;
      logic [31:0] ix, iz, sd;
      sum = 0;
      for (int k = 0; k < OCT; k++) begin
        fq = longint'(freq) << k;
        sd = seed + 32'(k) * 32'd1000;
        px = longint'(x) * fq;
        pz = longint'(z) * fq;
        ix = 32'(fshr(px, 2 * F));
        iz = 32'(fshr(pz, 2 * F));
        tx = (px >> F) & 64'hFFFF;
        tz = (pz >> F) & 64'hFFFF;
        sx = smooth(tx);
        sz = smooth(tz);
        r0 = mix(corner(ix, iz, sd), corner(ix + 1, iz, sd), sx);
        r1 = mix(corner(ix, iz + 1, sd), corner(ix + 1, iz + 1, sd), sx);
        nz = mix(r0, r1, sz);
        sum += fshr(nz * longint'(amp), F + k);
      end
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return 32'(sum);
    endfunction

    function void note_point(logic [63:0] d, logic [23:0] a, logic [23:0] f,
                             logic [31:0] s);
      pending.push_back(fbm_height(d[31:0], d[63:32], a, f, s));
    endfunction

    function void check_height(logic [31:0] got);
      logic signed [31:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected height beat %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: height mismatch: expected %0d, got %0d", want, $signed(got));
      end
    endfunction
  endclass

  height_board board = new();

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Score input beats, result beats and config writes at each edge.
  always @(posedge clk) begin
    if (rst) begin
      amp_q <= AMPLITUDE_RESET; freq_q <= BASE_FREQUENCY_RESET; seed_q <= NOISE_SEED_RESET;
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) board.note_point(s_tdata, amp_q, freq_q, seed_q);
      if (m_tvalid && m_tready) board.check_height(m_tdata);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AMPLITUDE:      amp_q  <= cfg_data[23:0];
          CFG_BASE_FREQUENCY: freq_q <= cfg_data[23:0];
          CFG_NOISE_SEED:     seed_q <= cfg_data;
          default: ;
        endcase
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: stop when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst && idle_cycles > WDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stalls: random-length ready stretches, most followed by a stall stretch.
  initial begin
    int run;
    m_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      run = $urandom_range(1, 30);
      repeat (run) @(posedge clk) m_tready <= 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        run = $urandom_range(1, 8);
        repeat (run) @(posedge clk) m_tready <= 1'b0;
      end
    end
  end

  // Send one point; gaps are governed by the burst counter.
  int burst_left;
  task automatic send_point(logic [31:0] x, logic [31:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {z, x};
    do @(posedge clk); while (!s_tready);
    // hold valid here; next call raises or drops it
    n_points++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and let the pipeline empty before touching registers.
  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0 && guard < WDOG) begin
      @(posedge clk);
      guard++;
    end
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($urandom_range(0, 32'h7FFF)) << $urandom_range(0, 16);
    endcase
  endfunction

  initial begin
    logic [31:0] ext[6];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000};
    rst = 1; s_tvalid = 0; s_tdata = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    burst_left = 0; n_points = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes at reset settings, plus lattice wrap.
    foreach (ext[i]) send_point(ext[i], ext[5 - i]);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    // Maximum amplitude, frequency and seed: saturation and huge lattice index.
    write_reg(CFG_AMPLITUDE, 32'hFFFF_FFFF);
    write_reg(CFG_BASE_FREQUENCY, 32'hFFFF_FFFF);
    write_reg(CFG_NOISE_SEED, 32'hFFFF_FFFF);
    write_reg(2'd3, 32'h1234_5678);   // unknown index: no effect
    foreach (ext[i]) send_point(ext[i], ext[(i + 2) % 6]);
    send_point(32'h0000_0000, 32'h0000_0000);
    drain();
    // Zero settings.
    write_reg(CFG_AMPLITUDE, 32'h0);
    write_reg(CFG_BASE_FREQUENCY, 32'h0);
    write_reg(CFG_NOISE_SEED, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h1234_5678, 32'h9ABC_DEF0);
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_AMPLITUDE,
                ph == 0 ? 32'(AMPLITUDE_RESET) : (ph == 1 ? 32'h00FF_FFFF : $urandom()));
      write_reg(CFG_BASE_FREQUENCY,
                ph == 0 ? 32'(BASE_FREQUENCY_RESET) : (ph == 2 ? 32'h00FF_FFFF :
                ph == 3 ? 32'h1 : $urandom_range(0, 32'h0004_0000)));
      write_reg(CFG_NOISE_SEED, $urandom());
      repeat (N_RAND / 8) send_point(rand_coord(), rand_coord());
      drain();
    end

    $display("Covered %0d points across directed extremes and 8 random register settings;",
             n_points);
    $display("%0d heights compared, %0d mismatches.", board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
